// File: sv/pta_pkg.sv
`default_nettype none

package pta_pkg;

  localparam int FRAC_BITS_DEFAULT = 8;
  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W = PROD_W + 2;
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ROTATE,
    OP_SCALE,
    OP_TRANSFORM
  } opcode_t;

  typedef enum logic [1:0] {
    QT_0,
    QT_90,
    QT_180,
    QT_270
  } qturn_t;

  typedef struct packed {
    opcode_t op;
    qturn_t qt;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic clip;
  } res_t;

  function automatic logic sat_ovf(input logic signed [SUM_W-1:0] v);
    sat_ovf = (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    if (v > SAT_MAX) begin
      sat16 = DATA_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      sat16 = DATA_W'(SAT_MIN);
    end else begin
      sat16 = v[DATA_W-1:0];
    end
  endfunction

  // Negation that saturates the most negative value.
  function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] v);
    if (v == DATA_W'(SAT_MIN)) begin
      neg_sat = DATA_W'(SAT_MAX);
    end else begin
      neg_sat = -v;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/pta_core.sv
`default_nettype none

module pta_core #(
  parameter int FRAC_BITS = pta_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire pta_pkg::cmd_t  cmd,
  output pta_pkg::res_t       res
);

  localparam int DataW = pta_pkg::DATA_W;
  localparam int ProdW = pta_pkg::PROD_W;
  localparam int SumW = pta_pkg::SUM_W;
  localparam int UnitRaw = 1 << FRAC_BITS;
  localparam int UnitInt = (UnitRaw > pta_pkg::SAT_MAX) ? pta_pkg::SAT_MAX : UnitRaw;
  localparam int HalfInt = 1 << (FRAC_BITS - 1);

  logic signed [DataW-1:0] unit_val;
  logic signed [DataW-1:0] mat [4];
  logic signed [DataW-1:0] mat_next [4];
  logic signed [DataW-1:0] mul_op [4];
  logic signed [ProdW-1:0] prod [4];
  logic signed [SumW-1:0]  rnd [4];
  logic signed [SumW-1:0]  rnd_x;
  logic signed [SumW-1:0]  rnd_y;
  logic                    is_scale;

  assign unit_val = DataW'(UnitInt);
  assign is_scale = (cmd.op == pta_pkg::OP_SCALE);

  always_comb begin
    mul_op[0] = cmd.a;
    mul_op[1] = is_scale ? cmd.a : cmd.b;
    mul_op[2] = is_scale ? cmd.b : cmd.a;
    mul_op[3] = cmd.b;
    for (int i = 0; i < 4; i++) begin
      prod[i] = ProdW'(mat[i]) * ProdW'(mul_op[i]);
      rnd[i] = (SumW'(prod[i]) + SumW'(HalfInt)) >>> FRAC_BITS;
    end
    rnd_x = (SumW'(prod[0]) + SumW'(prod[1]) + SumW'(HalfInt)) >>> FRAC_BITS;
    rnd_y = (SumW'(prod[2]) + SumW'(prod[3]) + SumW'(HalfInt)) >>> FRAC_BITS;
  end

  always_comb begin
    res.x = pta_pkg::sat16(rnd_x);
    res.y = pta_pkg::sat16(rnd_y);
    res.clip = pta_pkg::sat_ovf(rnd_x) | pta_pkg::sat_ovf(rnd_y);
  end

  always_comb begin
    mat_next = mat;
    case (cmd.op)
      pta_pkg::OP_CLEAR: begin
        mat_next[0] = unit_val;
        mat_next[1] = '0;
        mat_next[2] = '0;
        mat_next[3] = unit_val;
      end
      pta_pkg::OP_ROTATE: begin
        case (cmd.qt)
          pta_pkg::QT_90: begin
            mat_next[0] = mat[2];
            mat_next[1] = mat[3];
            mat_next[2] = pta_pkg::neg_sat(mat[0]);
            mat_next[3] = pta_pkg::neg_sat(mat[1]);
          end
          pta_pkg::QT_180: begin
            for (int i = 0; i < 4; i++) begin
              mat_next[i] = pta_pkg::neg_sat(mat[i]);
            end
          end
          pta_pkg::QT_270: begin
            mat_next[0] = pta_pkg::neg_sat(mat[2]);
            mat_next[1] = pta_pkg::neg_sat(mat[3]);
            mat_next[2] = mat[0];
            mat_next[3] = mat[1];
          end
          default: begin
            mat_next = mat;
          end
        endcase
      end
      pta_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          mat_next[i] = pta_pkg::sat16(rnd[i]);
        end
      end
      default: begin
        mat_next = mat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= unit_val;
      mat[1] <= '0;
      mat[2] <= '0;
      mat[3] <= unit_val;
    end else if (cmd_valid) begin
      mat <= mat_next;
    end
  end

  a_reset_identity: assert property (@(posedge clk)
    rst |=> (mat[0] == unit_val) && (mat[1] == '0) && (mat[2] == '0) && (mat[3] == unit_val))
    else $error("Matrix is not identity after reset.");

  a_clear_identity: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd.op == pta_pkg::OP_CLEAR)
      |=> (mat[0] == unit_val) && (mat[1] == '0) && (mat[2] == '0) && (mat[3] == unit_val))
    else $error("Clear did not load the identity.");

  a_transform_keeps_matrix: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd.op == pta_pkg::OP_TRANSFORM)
      |=> $stable(mat[0]) && $stable(mat[1]) && $stable(mat[2]) && $stable(mat[3]))
    else $error("Transform changed the matrix.");

endmodule

`default_nettype wire

// File: sv/planar_transform_accumulator.sv
// Planar transform accumulator: keeps a 2x2 fixed-point matrix and applies it.
// The slave channel takes one command word per cycle while s_tready is high:
// s_tuser is the opcode (clear, rotate, scale, transform) and s_tdata carries
// the rotation code and the two operands. Clear, rotate and scale update the
// matrix and give no word on the master channel; transform gives one word with
// the rounded, saturated point on m_tdata and the saturation flag on m_tuser.
// A command word sits in an input register, where four parallel 16x16
// multipliers with rounding and saturation compute the matrix update or the
// transformed point; the point goes to an output register, which drives the
// master channel. Throughput is one word per cycle while the receiver does not
// stall, and commands that update the matrix take effect for the word right
// behind them.
// When the receiver stalls, the result waits in the output register and the
// next word waits in the input register, so at most two words are held before
// s_tready drops; matrix-update words keep flowing while the result waits.
// Reset loads the identity matrix and empties both registers.
`default_nettype none

module planar_transform_accumulator #(
  parameter int FRAC_BITS = pta_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // quarter_turns[1:0], operand_a[17:2], operand_b[33:18]
  input  wire logic [1:0]  s_tuser,   // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // out_x[15:0], out_y[31:16]
  output logic             m_tuser    // clipped[0]
);

  logic           in_valid;
  pta_pkg::cmd_t  in_cmd;
  pta_pkg::cmd_t  s_cmd;
  pta_pkg::res_t  res;
  logic           out_free;
  logic           fire;
  logic           fire_xform;

  always_comb begin
    s_cmd.op = pta_pkg::opcode_t'(s_tuser);
    s_cmd.qt = pta_pkg::qturn_t'(s_tdata[1:0]);
    s_cmd.a  = s_tdata[17:2];
    s_cmd.b  = s_tdata[33:18];
  end

  assign out_free   = !m_tvalid || m_tready;
  assign fire       = in_valid && ((in_cmd.op != pta_pkg::OP_TRANSFORM) || out_free);
  assign fire_xform = fire && (in_cmd.op == pta_pkg::OP_TRANSFORM);
  assign s_tready   = !in_valid || fire;

  pta_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cmd_valid(fire),
    .cmd(in_cmd),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (fire_xform) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_cmd;
    end
    if (fire_xform) begin
      m_tdata <= {res.y, res.x};
      m_tuser <= res.clip;
    end
  end

  a_update_never_waits: assert property (@(posedge clk) disable iff (rst)
    in_valid && (in_cmd.op != pta_pkg::OP_TRANSFORM) |-> fire)
    else $error("A matrix update word was held.");

  a_transform_reaches_output: assert property (@(posedge clk) disable iff (rst)
    fire_xform |=> m_tvalid)
    else $error("A transform result was lost.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("Input stalled while there was room.");

endmodule

`default_nettype wire
